// ----- hw/rtl/pfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared constants, codes and types for the page frame stack allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 4096;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int WALK_W   = 34;  // page cursor, may step past a 33-bit end
  localparam int END_W    = 33;  // base + length, no wrap
  localparam int ADDED_W  = 13;
  localparam int PAGE_OFS = 12;

  localparam logic [ADDR_W-1:0]  LOW_MEM_LIMIT = 32'h0010_0000;
  localparam logic [WALK_W-1:0]  PAGE_STEP     = 34'h0_0000_1000;
  localparam logic [7:0]         TYPE_USABLE   = 8'd1;

  // Opcodes
  localparam logic [1:0] OP_FREE   = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_REGION = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_KERNEL_BASE    = 2'd0;
  localparam logic [1:0] REG_KERNEL_LIMIT   = 2'd1;
  localparam logic [1:0] REG_RESERVED_BASE  = 2'd2;
  localparam logic [1:0] REG_RESERVED_LIMIT = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_length;
    logic [7:0]        region_type;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] kernel_base;
    logic [ADDR_W-1:0] kernel_limit;
    logic [ADDR_W-1:0] reserved_base;
    logic [ADDR_W-1:0] reserved_limit;
  } excl_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  alloc_address;
    logic [1:0]         status;
    logic [ADDED_W-1:0] pages_added;
    logic               is_full;
    logic               is_empty;
  } res_t;

endpackage

// ----- hw/rtl/pfsa_ram.sv -----
// ----------------------------------------------------------------------------
// pfsa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfsa_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/pfsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfsa_ctrl
// Operation sequencer: push, pop and region walk over the stack RAM.
// ----------------------------------------------------------------------------
module pfsa_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  pfsa_pkg::item_t                 item,
  input  pfsa_pkg::excl_t                 excl,
  output logic                            res_valid,
  input  logic                            res_take,
  output pfsa_pkg::res_t                  res,
  output logic                            mem_wr_en,
  output logic [pfsa_pkg::PTR_W-1:0]      mem_wr_addr,
  output logic [pfsa_pkg::ADDR_W-1:0]     mem_wr_data,
  output logic                            mem_rd_en,
  output logic [pfsa_pkg::PTR_W-1:0]      mem_rd_addr,
  input  logic [pfsa_pkg::ADDR_W-1:0]     mem_rd_data
);
  import pfsa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_r,  state_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic [WALK_W-1:0]  page_r,   page_nxt;
  logic [END_W-1:0]   end_r,    end_nxt;
  logic [ADDR_W-1:0]  alloc_r,  alloc_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [ADDED_W-1:0] added_r,  added_nxt;

  logic               full;
  logic               accept;
  logic [CNT_W-1:0]   count_dec;
  logic [WALK_W-1:0]  page_start;
  logic               in_kernel;
  logic               in_reserved;
  logic               walk_more;

  assign full      = (count_r == DEPTH_CNT);
  assign accept    = item_valid && item_ready;
  assign count_dec = count_r - CNT_W'(1);

  // Region base rounded up to a page boundary, in walk width
  always_comb begin
    page_start = {{(WALK_W-ADDR_W){1'b0}}, item.address};
    if (item.address[PAGE_OFS-1:0] != '0) begin
      page_start = {{(WALK_W-ADDR_W){1'b0}}, item.address[ADDR_W-1:PAGE_OFS],
                    {PAGE_OFS{1'b0}}} + PAGE_STEP;
    end
  end

  assign in_kernel   = (page_r >= {2'b00, excl.kernel_base}) &&
                       (page_r <  {2'b00, excl.kernel_limit});
  assign in_reserved = (page_r >= {2'b00, excl.reserved_base}) &&
                       (page_r <  {2'b00, excl.reserved_limit});
  assign walk_more   = (page_r < {1'b0, end_r});

  assign item_ready  = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);

  assign res.alloc_address = alloc_r;
  assign res.status        = status_r;
  assign res.pages_added   = added_r;
  assign res.is_full       = full;
  assign res.is_empty      = (count_r == '0);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    page_nxt    = page_r;
    end_nxt     = end_r;
    alloc_nxt   = alloc_r;
    status_nxt  = status_r;
    added_nxt   = added_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = count_r[PTR_W-1:0];
    mem_wr_data = item.address;
    mem_rd_en   = 1'b0;
    mem_rd_addr = count_dec[PTR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          alloc_nxt  = '0;
          added_nxt  = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          unique case (item.opcode)
            OP_FREE: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_wr_en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_ALLOC: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_rd_en = 1'b1;
                count_nxt = count_dec;
                state_nxt = S_POP;
              end
            end
            OP_REGION: begin
              if (item.region_type != TYPE_USABLE || item.address < LOW_MEM_LIMIT) begin
                status_nxt = ST_IGNORED;
              end else begin
                page_nxt  = page_start;
                end_nxt   = {1'b0, item.address} + {1'b0, item.region_length};
                state_nxt = S_WALK;
              end
            end
            default: begin
              status_nxt = ST_IGNORED;
            end
          endcase
        end
      end

      S_POP: begin
        alloc_nxt = mem_rd_data;
        state_nxt = S_DONE;
      end

      S_WALK: begin
        mem_wr_data = page_r[ADDR_W-1:0];
        if (!walk_more) begin
          state_nxt = S_DONE;
        end else if (in_kernel || in_reserved) begin
          page_nxt = page_r + PAGE_STEP;
        end else if (full) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          mem_wr_en = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          page_nxt  = page_r + PAGE_STEP;
          if (added_r != '1) begin
            added_nxt = added_r + ADDED_W'(1);
          end
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      page_r  <= '0;
      end_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      page_r  <= page_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alloc_r  <= alloc_nxt;
    status_r <= status_nxt;
    added_r  <= added_nxt;
  end

endmodule

// ----- hw/rtl/page_frame_stack_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_stack_allocator
// LIFO stack of free 4 KiB page addresses: free, allocate and add-region.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// in_       in   in_tvalid/tready   tuser: opcode; tdata: address, length, type
// out_      out  out_tvalid/tready  tuser: status; tdata: alloc addr, pages, flags
// cfg_      in   cfg_wr_en          cfg_index selects register, cfg_wdata value
//
// Steps: free writes the stack RAM on acceptance; allocate reads it on
// acceptance and takes the registered read data in its pop state;
// add-region walks the region one page at a time, pages in the excluded
// ranges included. A transaction is accepted only while the sequencer
// is idle, but it may start while the previous result still sits in the
// output register. Reset (synchronous, active low) empties the stack and
// clears the excluded ranges; RAM contents are left as they are. A stalled
// output holds the sequencer in its result state until the register frees.
//
module page_frame_stack_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [31:0] address, [63:32] region_length,
                                  // [71:64] region_type
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // Result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] alloc_address, [44:32] pages_added,
                                  // [45] is_full, [46] is_empty, [47] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // Configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import pfsa_pkg::*;

  // Excluded ranges
  excl_t excl_r, excl_nxt;

  always_comb begin
    excl_nxt = excl_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KERNEL_BASE:    excl_nxt.kernel_base    = cfg_wdata;
        REG_KERNEL_LIMIT:   excl_nxt.kernel_limit   = cfg_wdata;
        REG_RESERVED_BASE:  excl_nxt.reserved_base  = cfg_wdata;
        REG_RESERVED_LIMIT: excl_nxt.reserved_limit = cfg_wdata;
        default:            excl_nxt = excl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_r <= '0;
    end else begin
      excl_r <= excl_nxt;
    end
  end

  // Unpack the incoming transaction
  item_t item;
  assign item.opcode        = in_tuser;
  assign item.address       = in_tdata[31:0];
  assign item.region_length = in_tdata[63:32];
  assign item.region_type   = in_tdata[71:64];

  // Sequencer <-> stack RAM
  logic              mem_wr_en;
  logic [PTR_W-1:0]  mem_wr_addr;
  logic [ADDR_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [PTR_W-1:0]  mem_rd_addr;
  logic [ADDR_W-1:0] mem_rd_data;

  logic res_valid;
  logic res_take;
  res_t res;

  pfsa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item        (item),
    .excl        (excl_r),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  pfsa_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (ADDR_W)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: loads when empty or being drained this cycle
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r,   out_res_nxt;

  assign res_take = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0, out_res_r.is_empty, out_res_r.is_full,
                       out_res_r.pages_added, out_res_r.alloc_address};

endmodule

// ----- sim/stack_ledger_pkg.sv -----
// ----------------------------------------------------------------------------
// stack_ledger_pkg
// Mirror of the free page stack: predicts each result and checks the DUT.
// ----------------------------------------------------------------------------
package stack_ledger_pkg;

  import pfsa_pkg::*;

  class stack_ledger;
    logic [ADDR_W-1:0] page_store [STACK_DEPTH];
    int                held;
    excl_t             ranges;
    res_t              replies_due [$];
    int                mismatches;
    int                checked;
    int                status_seen [4];
    int                pages_pushed;

    function new();
      held         = 0;
      ranges       = '0;
      mismatches   = 0;
      checked      = 0;
      pages_pushed = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_KERNEL_BASE:    ranges.kernel_base    = value;
        REG_KERNEL_LIMIT:   ranges.kernel_limit   = value;
        REG_RESERVED_BASE:  ranges.reserved_base  = value;
        REG_RESERVED_LIMIT: ranges.reserved_limit = value;
        default: ;
      endcase
    endfunction

    // base <= page < limit; an empty or inverted range matches nothing
    function bit excluded(logic [WALK_W-1:0] page);
      return (page >= WALK_W'(ranges.kernel_base) &&
              page <  WALK_W'(ranges.kernel_limit)) ||
             (page >= WALK_W'(ranges.reserved_base) &&
              page <  WALK_W'(ranges.reserved_limit));
    endfunction

    // Applies one transaction to the mirrored stack, returns the result due
    function res_t next_reply(item_t it);
      res_t              r;
      logic [WALK_W-1:0] page;
      logic [WALK_W-1:0] walk_end;
      r = '0;
      case (it.opcode)
        OP_FREE: begin
          if (held >= STACK_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            page_store[held] = it.address;
            held++;
          end
        end
        OP_ALLOC: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            held--;
            r.alloc_address = page_store[held];
          end
        end
        OP_REGION: begin
          if (it.region_type != TYPE_USABLE || it.address < LOW_MEM_LIMIT) begin
            r.status = ST_IGNORED;
          end else begin
            // round up to a page; the cursor may pass 2^32
            page = WALK_W'(it.address);
            if (page[PAGE_OFS-1:0] != '0) begin
              page[PAGE_OFS-1:0] = '0;
              page = page + PAGE_STEP;
            end
            walk_end = WALK_W'(it.address) + WALK_W'(it.region_length);
            while (page < walk_end) begin
              if (!excluded(page)) begin
                if (held >= STACK_DEPTH) begin
                  r.status = ST_FULL;
                  break;
                end
                page_store[held] = page[ADDR_W-1:0];
                held++;
                if (r.pages_added != '1) r.pages_added = r.pages_added + 1'b1;
              end
              page = page + PAGE_STEP;
            end
            pages_pushed += r.pages_added;
          end
        end
        default: r.status = ST_IGNORED;
      endcase
      r.is_full  = (held >= STACK_DEPTH);
      r.is_empty = (held == 0);
      return r;
    endfunction

    function void note_request(item_t it);
      replies_due.push_back(next_reply(it));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                  checked, name, got, want));
    endtask

    task check_reply(res_t got, logic pad);
      res_t want;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d addr 0x%0h",
                                  got.status, got.alloc_address));
        return;
      end
      want = replies_due.pop_front();
      checked++;
      status_seen[want.status]++;
      compare_field("alloc_address", got.alloc_address, want.alloc_address);
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("pages_added", 32'(got.pages_added), 32'(want.pages_added));
      compare_field("is_full", 32'(got.is_full), 32'(want.is_full));
      compare_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
      compare_field("pad bit", 32'(pad), 32'd0);
    endtask

    task flush_leftover();
      while (replies_due.size() != 0) begin
        report_mismatch($sformatf("result never arrived, status %0d due",
                                  replies_due[0].status));
        void'(replies_due.pop_front());
      end
    endtask
  endclass

endpackage

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the page frame stack allocator. Free, allocate and
// add-region transactions go in, every result is checked against a mirrored
// stack, with random idling on both sides and several exclusion settings.
// ----------------------------------------------------------------------------
module tb_top;

  import pfsa_pkg::*;
  import stack_ledger_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int          SETTLE_CYCLES = 4;       // sequencer back to idle
  localparam int          DRAIN_LIMIT   = 50_000;  // > one full-stack walk
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_ITEMS   = 175;
  localparam int          TOPUP_ITEMS   = 240;

  localparam logic [1:0]  OP_SPARE      = 2'd3;    // no-op opcode

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // [31:0] address, [63:32] region_length,
                                  // [71:64] region_type
  logic [1:0]  in_tuser   = '0;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [31:0] alloc_address, [44:32] pages_added,
                                  // [45] is_full, [46] is_empty, [47] zero
  logic [1:0]  out_tuser;         // [1:0] status
  logic        cfg_wr_en  = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_wdata  = '0;

  stack_ledger ledger;
  bit          gaps_on      = 1'b1;
  int unsigned cycle_count  = 0;
  int          sent         = 0;
  int          stall_left   = 0;
  res_t        seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  page_frame_stack_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Idle length for either side: mostly none or short, now and then long.
  // gaps_on cleared gives stretches at full rate.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               ledger.replies_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick next tready.
  // Values are sampled as they stood before this edge.
  always @(posedge clk) begin
    int g;
    if (rst_n && out_tvalid && out_tready) begin
      seen.alloc_address = out_tdata[31:0];
      seen.pages_added   = out_tdata[44:32];
      seen.is_full       = out_tdata[45];
      seen.is_empty      = out_tdata[46];
      seen.status        = out_tuser;
      ledger.check_reply(seen, out_tdata[47]);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        stall_left = g - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One input transaction. tvalid stays high into the next call when that
  // call has no gap, so it is never dropped and raised in the same step.
  task automatic send_request(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.region_type, it.region_length, it.address};
    in_tuser  <= it.opcode;
    do @(posedge clk); while (!in_tready);
    ledger.note_request(it);
    sent++;
  endtask

  // Wait for every result, then give the sequencer time to go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (ledger.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(input logic [1:0] index, input logic [31:0] value);
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.write_register(index, value);
  endtask

  // Four back-to-back writes, enable held high across them
  task automatic load_ranges(input logic [31:0] kb, input logic [31:0] kl,
                             input logic [31:0] rb, input logic [31:0] rl);
    cfg_wr_en <= 1'b1;
    put_register(REG_KERNEL_BASE, kb);
    put_register(REG_KERNEL_LIMIT, kl);
    put_register(REG_RESERVED_BASE, rb);
    put_register(REG_RESERVED_LIMIT, rl);
    cfg_wr_en <= 1'b0;
  endtask

  // Exclusion settings:
  //   0 none, 1 small ranges over the 1-2 MiB window (bounds unaligned at
  //   times), 2 everything below the top excluded, 3 inverted ranges,
  //   4 fully random bounds
  task automatic load_style(input int style);
    logic [31:0] kb, kl, rb, rl;
    kb = '0; kl = '0; rb = '0; rl = '0;
    case (style)
      1: begin
        kb = LOW_MEM_LIMIT + 32'($urandom_range(0, 255)) * 32'h1000;
        if ($urandom_range(0, 1)) kb = kb + 32'($urandom_range(0, 32'hFFF));
        kl = kb + 32'($urandom_range(0, 48)) * 32'h1000 + 32'($urandom_range(0, 32'hFFF));
        rb = LOW_MEM_LIMIT + 32'($urandom_range(0, 255)) * 32'h1000;
        if ($urandom_range(0, 1)) rb = rb + 32'($urandom_range(0, 32'hFFF));
        rl = rb + 32'($urandom_range(0, 48)) * 32'h1000 + 32'($urandom_range(0, 32'hFFF));
      end
      2: begin
        kb = 32'h0000_0000;  kl = 32'hFFFF_FFFF;
        rb = 32'hFFFF_FFFF;  rl = 32'hFFFF_FFFF;
      end
      3: begin
        kb = 32'hFFFF_FFFF;  kl = 32'h0000_0000;
        rb = 32'h0018_0000;  rl = 32'h0010_0000;
      end
      4: begin
        kb = $urandom();  kl = $urandom();
        rb = $urandom();  rl = $urandom();
      end
      default: ;
    endcase
    load_ranges(kb, kl, rb, rl);
  endtask

  function automatic item_t make_item(input logic [1:0] op, input logic [31:0] addr,
                                      input logic [31:0] len, input logic [7:0] rtype);
    item_t it;
    it.opcode        = op;
    it.address       = addr;
    it.region_length = len;
    it.region_type   = rtype;
    return it;
  endfunction

  // Random transaction mix. Region walks are kept short unless wide is set;
  // wide regions take any length and rely on the stack filling to end them.
  // The remainder of the mix is noise: ignored regions and the spare opcode.
  function automatic item_t random_item(input int alloc_pct, input int free_pct,
                                        input int region_pct, input int max_pages,
                                        input bit wide);
    item_t       it;
    int          r;
    int          pick;
    logic [31:0] addr;
    logic [31:0] len;
    logic [7:0]  rtype;
    it = make_item(OP_FREE, $urandom(), $urandom(), 8'($urandom()));
    r  = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      it.opcode = OP_ALLOC;
    end else if (r < alloc_pct + free_pct) begin
      it.opcode = OP_FREE;
    end else if (r < alloc_pct + free_pct + region_pct) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        addr = LOW_MEM_LIMIT + 32'($urandom_range(0, 32'h000F_FFFF));
      else if (pick < 9)
        addr = $urandom_range(32'hFFFF_FFFF, LOW_MEM_LIMIT);
      else
        addr = 32'hFFFF_0000 + 32'($urandom_range(0, 32'hFFFF));
      if (wide)
        len = $urandom();
      else if ($urandom_range(0, 99) < 3)
        len = 32'($urandom_range(0, 64)) * 32'h1000 + 32'($urandom_range(0, 32'hFFF));
      else
        len = 32'($urandom_range(0, max_pages)) * 32'h1000 + 32'($urandom_range(0, 32'hFFF));
      it = make_item(OP_REGION, addr, len, TYPE_USABLE);
    end else if ($urandom_range(0, 1)) begin
      it.opcode = 2'($urandom_range(0, 3));
      if (it.opcode != OP_REGION) it.opcode = OP_SPARE;
      if (it.opcode == OP_REGION) it.region_type = 8'($urandom_range(2, 255));
    end else begin
      // usable type below 1 MiB, or any other type anywhere
      rtype = 8'($urandom_range(0, 255));
      if (rtype == TYPE_USABLE || $urandom_range(0, 3) == 0) begin
        rtype = TYPE_USABLE;
        addr  = $urandom_range(LOW_MEM_LIMIT - 1, 0);
      end else begin
        addr = $urandom();
      end
      it = make_item(OP_REGION, addr, $urandom(), rtype);
    end
    return it;
  endfunction

  initial begin
    int waited;
    ledger = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed: empty stack, no exclusions ----------------
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));            // pop on empty
    send_request(make_item(OP_SPARE, '1, '1, '1));                    // spare opcode
    send_request(make_item(OP_FREE, 32'h0000_0000, 32'h0, 8'h0));
    send_request(make_item(OP_FREE, 32'hFFFF_FFFF, '1, '1));
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));            // empty again
    send_request(make_item(OP_REGION, 32'h0020_0000, 32'h4000, 8'h00));
    send_request(make_item(OP_REGION, 32'h0020_0000, 32'h4000, 8'hFF));
    send_request(make_item(OP_REGION, 32'h000F_FFFF, 32'h4000, TYPE_USABLE));
    send_request(make_item(OP_REGION, 32'h0010_0000, 32'h3000, TYPE_USABLE));
    send_request(make_item(OP_REGION, 32'h0010_0001, 32'h3000, TYPE_USABLE)); // round up
    send_request(make_item(OP_REGION, 32'h0020_0000, 32'h0, TYPE_USABLE));    // zero length
    // base rounds past 2^32: nothing left below the end
    send_request(make_item(OP_REGION, 32'hFFFF_FFFF, 32'h0, TYPE_USABLE));
    // pages at and past 2^32 below a 33-bit end go in truncated
    send_request(make_item(OP_REGION, 32'hFFFF_F800, 32'h1800, TYPE_USABLE));
    send_request(make_item(OP_REGION, 32'hFFFF_F000, 32'h1001, TYPE_USABLE));
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));

    // overlapping kernel and reserved ranges, walk across both edges
    settle();
    load_ranges(32'h0030_0000, 32'h0030_5000, 32'h0030_4000, 32'h0030_8000);
    send_request(make_item(OP_REGION, 32'h002F_E000, 32'h0001_0000, TYPE_USABLE));
    send_request(make_item(OP_REGION, 32'h0030_0800, 32'h0000_6000, TYPE_USABLE));
    // inverted ranges exclude nothing
    settle();
    load_ranges(32'h0040_0000, 32'h003F_F000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(make_item(OP_REGION, 32'h003F_F000, 32'h2000, TYPE_USABLE));

    // ---------------- random phases near empty ----------------------------
    // Even phases lean on allocate and drain toward empty, odd ones grow.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      settle();
      load_style(k % 5);
      gaps_on = (k != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (k % 2 == 0)
          send_request(random_item(60, 15, 10, 2, 1'b0));
        else
          send_request(random_item(35, 35, 15, 4, 1'b0));
      end
    end
    gaps_on = 1'b1;

    // ---------------- directed: full stack --------------------------------
    settle();
    load_ranges(32'h0018_0000, 32'h0019_0000, 32'h001A_0800, 32'h001A_2800);
    send_request(make_item(OP_REGION, 32'h0010_0000, 32'hFFFF_FFFF, TYPE_USABLE)); // fills
    send_request(make_item(OP_FREE, 32'h1234_5000, 32'h0, 8'h0));                  // full
    send_request(make_item(OP_REGION, 32'h0020_0000, 32'h0, TYPE_USABLE));
    send_request(make_item(OP_REGION, 32'h0018_0000, 32'h0001_0000, TYPE_USABLE)); // all excluded
    send_request(make_item(OP_REGION, 32'h0020_0000, 32'h1000, TYPE_USABLE));      // page left
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));
    // one push fills it, the pages after it are excluded
    send_request(make_item(OP_REGION, 32'h0017_F000, 32'h3000, TYPE_USABLE));
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));
    send_request(make_item(OP_REGION, 32'h001A_0000, 32'h4000, TYPE_USABLE));
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));
    send_request(make_item(OP_FREE, 32'hFFFF_FFFF, 32'h0, 8'h0));
    send_request(make_item(OP_ALLOC, 32'h0, 32'h0, 8'h0));

    // ---------------- random near full, any region length -----------------
    settle();
    load_style(1);
    for (int n = 0; n < TOPUP_ITEMS; n++) begin
      gaps_on = ((n / 60) % 2 == 0);
      send_request(random_item(30, 30, 25, 4, 1'b1));
    end
    gaps_on = 1'b1;

    // ---------------- wind down -------------------------------------------
    in_tvalid <= 1'b0;
    waited = 0;
    while (ledger.replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    ledger.flush_leftover();

    $display("Sent %0d transactions, checked %0d results: ok %0d, full %0d, empty %0d, ignored %0d",
             sent, ledger.checked, ledger.status_seen[ST_OK], ledger.status_seen[ST_FULL],
             ledger.status_seen[ST_EMPTY], ledger.status_seen[ST_IGNORED]);
    $display("Region walks pushed %0d pages; %0d mismatches", ledger.pages_pushed,
             ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
